FILE: hw/rtl/mte_pkg.sv
package mte_pkg;

  localparam int NUM_SLOTS_DEF    = 1024;
  localparam int THREAD_BITS_DEF  = 16;
  localparam int COUNT_BITS_DEF   = 16;
  localparam int SLOT_FIELD_LIMIT = 1024;
  localparam int ROW_BITS         = 32;

  localparam logic [2:0] REQ_ALLOC   = 3'd0;
  localparam logic [2:0] REQ_FREE    = 3'd1;
  localparam logic [2:0] REQ_LOCK    = 3'd2;
  localparam logic [2:0] REQ_TRYLOCK = 3'd3;
  localparam logic [2:0] REQ_UNLOCK  = 3'd4;

  localparam logic [2:0] STS_OK       = 3'd0;
  localparam logic [2:0] STS_INVALID  = 3'd1;
  localparam logic [2:0] STS_NOFREE   = 3'd2;
  localparam logic [2:0] STS_DEADLOCK = 3'd3;
  localparam logic [2:0] STS_BUSY     = 3'd4;
  localparam logic [2:0] STS_NOTOWNER = 3'd5;
  localparam logic [2:0] STS_RETRY    = 3'd6;
  localparam logic [2:0] STS_OVERFLOW = 3'd7;

  localparam logic [1:0] KIND_NORMAL     = 2'd0;
  localparam logic [1:0] KIND_RECURSIVE  = 2'd1;
  localparam logic [1:0] KIND_ERRORCHECK = 2'd2;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [9:0]  slot;
    logic [15:0] thread_id;
    logic [3:0]  mutex_kind;
  } mte_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [9:0]  granted_slot;
    logic [15:0] count_after;
  } mte_out_t;

  typedef enum logic [0:0] {
    S_IDLE,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
  } cmd_t;

  function automatic logic [1:0] kind_map(logic [3:0] k);
    logic [1:0] r;
    r = KIND_NORMAL;
    if (k == {2'b00, KIND_RECURSIVE}) r = KIND_RECURSIVE;
    else if (k == {2'b00, KIND_ERRORCHECK}) r = KIND_ERRORCHECK;
    return r;
  endfunction

endpackage

FILE: hw/rtl/mte_prienc.sv
module mte_prienc #(
  parameter int WIDTH = mte_pkg::ROW_BITS,
  parameter int IDX_W = (WIDTH > 1) ? $clog2(WIDTH) : 1
) (
  input  logic [WIDTH-1:0] vec,
  output logic [IDX_W-1:0] idx,
  output logic             any
);

  always_comb begin
    idx = '0;
    for (int i = WIDTH - 1; i >= 0; i--) begin
      if (vec[i]) idx = IDX_W'(i);
    end
    any = |vec;
  end

endmodule

FILE: hw/rtl/mte_ctrl.sv
module mte_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  output mte_pkg::cmd_t cmd,
  output logic          out_valid
);

  mte_pkg::state_t state_r, state_nxt;
  logic            out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mte_pkg::S_IDLE: begin
        if (start) state_nxt = mte_pkg::S_EXEC;
      end
      mte_pkg::S_EXEC: begin
        state_nxt = mte_pkg::S_IDLE;
      end
      default: begin
        state_nxt = mte_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b0;
    case (state_r)
      mte_pkg::S_IDLE: begin
        cmd.load = start;
      end
      mte_pkg::S_EXEC: begin
        cmd.exec = 1'b1;
        busy     = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mte_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= cmd.exec;
    end
  end

  assign out_valid = out_valid_r;

endmodule

FILE: hw/rtl/mte_dp.sv
module mte_dp #(
  parameter int NUM_SLOTS   = mte_pkg::NUM_SLOTS_DEF,
  parameter int THREAD_BITS = mte_pkg::THREAD_BITS_DEF,
  parameter int COUNT_BITS  = mte_pkg::COUNT_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  mte_pkg::cmd_t     cmd,
  input  mte_pkg::mte_in_t  in_req,
  output mte_pkg::mte_out_t out_res
);

  localparam int EFF_SLOTS = (NUM_SLOTS < mte_pkg::SLOT_FIELD_LIMIT) ?
                             NUM_SLOTS : mte_pkg::SLOT_FIELD_LIMIT;
  localparam int SLOT_W = $clog2(EFF_SLOTS);
  localparam int RB     = mte_pkg::ROW_BITS;
  localparam int BIT_W  = $clog2(RB);
  localparam int ROWS   = (EFF_SLOTS + RB - 1) / RB;
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;

  typedef struct packed {
    logic [1:0]             kind;
    logic                   ov;
    logic [THREAD_BITS-1:0] owner;
    logic [COUNT_BITS-1:0]  count;
  } ent_t;

  logic [RB-1:0] use_mem [ROWS];
  ent_t          ent_mem [EFF_SLOTS];

  logic [ROWS-1:0]  row_valid_r;
  logic [ROWS-1:0]  row_full_r;
  mte_pkg::mte_in_t req_r;
  logic [RB-1:0]    word_r;
  logic             rv_r;
  ent_t             ent_r;
  logic [ROW_W-1:0] row_r;
  logic             any_r;
  mte_pkg::mte_out_t out_r, out_nxt;

  // read side, at the transfer edge
  logic [ROWS-1:0]   row_free;
  logic [ROW_W-1:0]  pick_row;
  logic              row_any;
  logic              in_ok;
  logic              ld_alloc;
  logic [ROW_W-1:0]  rd_row;
  logic [SLOT_W-1:0] rd_slot;

  assign row_free = ~row_full_r;

  mte_prienc #(.WIDTH(ROWS), .IDX_W(ROW_W)) u_row_enc (
    .vec (row_free),
    .idx (pick_row),
    .any (row_any)
  );

  assign in_ok    = {1'b0, in_req.slot} < 11'(EFF_SLOTS);
  assign ld_alloc = in_req.req_type == mte_pkg::REQ_ALLOC;
  assign rd_row   = ld_alloc ? pick_row :
                    (in_ok ? ROW_W'(in_req.slot >> BIT_W) : '0);
  assign rd_slot  = in_ok ? SLOT_W'(in_req.slot) : '0;

  // execute side
  logic [RB-1:0]          word;
  logic [RB-1:0]          alloc_mask;
  logic [RB-1:0]          free_bits;
  logic [BIT_W-1:0]       pick_bit;
  logic                   bit_any;
  logic [SLOT_W-1:0]      gslot;
  logic                   slot_ok;
  logic [BIT_W-1:0]       bit_sel;
  logic                   in_use;
  logic                   is_alloc;
  logic                   valid_req;
  logic [THREAD_BITS-1:0] self;
  logic                   mine;
  logic                   at_max;
  logic [COUNT_BITS-1:0]  cnt_inc;
  logic [COUNT_BITS-1:0]  cnt_dec;
  logic                   use_we;
  logic [RB-1:0]          use_wdata;
  logic                   row_full_nxt;
  logic                   ent_we;
  logic [SLOT_W-1:0]      ent_waddr;
  ent_t                   ent_wdata;

  assign word = rv_r ? word_r : '0;

  always_comb begin
    for (int b = 0; b < RB; b++) begin
      alloc_mask[b] = {row_r, BIT_W'(b)} < (ROW_W + BIT_W + 1)'(EFF_SLOTS);
    end
  end

  assign free_bits = ~word & alloc_mask;

  mte_prienc #(.WIDTH(RB), .IDX_W(BIT_W)) u_bit_enc (
    .vec (free_bits),
    .idx (pick_bit),
    .any (bit_any)
  );

  assign gslot     = SLOT_W'({row_r, pick_bit});
  assign slot_ok   = {1'b0, req_r.slot} < 11'(EFF_SLOTS);
  assign bit_sel   = req_r.slot[BIT_W-1:0];
  assign in_use    = word[bit_sel];
  assign is_alloc  = req_r.req_type == mte_pkg::REQ_ALLOC;
  assign valid_req = (req_r.req_type inside {mte_pkg::REQ_FREE, mte_pkg::REQ_LOCK,
                      mte_pkg::REQ_TRYLOCK, mte_pkg::REQ_UNLOCK}) && slot_ok && in_use;
  assign self      = THREAD_BITS'(req_r.thread_id);
  assign mine      = ent_r.ov && (ent_r.owner == self);
  assign at_max    = &ent_r.count;
  assign cnt_inc   = ent_r.count + 1'b1;
  assign cnt_dec   = ent_r.count - 1'b1;

  always_comb begin
    out_nxt        = '0;
    out_nxt.status = mte_pkg::STS_INVALID;
    use_we         = 1'b0;
    use_wdata      = word;
    row_full_nxt   = 1'b0;
    ent_we         = 1'b0;
    ent_waddr      = SLOT_W'(req_r.slot);
    ent_wdata      = ent_r;
    if (is_alloc) begin
      if (any_r) begin
        out_nxt.status       = mte_pkg::STS_OK;
        out_nxt.granted_slot = 10'(gslot);
        use_we               = 1'b1;
        use_wdata            = word | (RB'(1) << pick_bit);
        row_full_nxt         = &(use_wdata | ~alloc_mask);
        ent_we               = 1'b1;
        ent_waddr            = gslot;
        ent_wdata            = '0;
        ent_wdata.kind       = mte_pkg::kind_map(req_r.mutex_kind);
      end else begin
        out_nxt.status = mte_pkg::STS_NOFREE;
      end
    end else if (valid_req) begin
      case (req_r.req_type)
        mte_pkg::REQ_FREE: begin
          use_we         = 1'b1;
          use_wdata      = word & ~(RB'(1) << bit_sel);
          out_nxt.status = mte_pkg::STS_OK;
        end
        mte_pkg::REQ_LOCK, mte_pkg::REQ_TRYLOCK: begin
          ent_we = 1'b1;
          if (!ent_r.ov || (!mine && req_r.req_type == mte_pkg::REQ_LOCK &&
                            ent_r.count == '0)) begin
            ent_wdata.ov    = 1'b1;
            ent_wdata.owner = self;
            if (at_max) begin
              out_nxt.status = mte_pkg::STS_OVERFLOW;
            end else begin
              ent_wdata.count = cnt_inc;
              out_nxt.status  = mte_pkg::STS_OK;
            end
          end else if (mine) begin
            if (ent_r.kind == mte_pkg::KIND_RECURSIVE) begin
              if (at_max) begin
                out_nxt.status = mte_pkg::STS_OVERFLOW;
              end else begin
                ent_wdata.count = cnt_inc;
                out_nxt.status  = mte_pkg::STS_OK;
              end
            end else begin
              out_nxt.status = (req_r.req_type == mte_pkg::REQ_LOCK) ?
                               mte_pkg::STS_DEADLOCK : mte_pkg::STS_BUSY;
            end
          end else if (req_r.req_type == mte_pkg::REQ_TRYLOCK) begin
            out_nxt.status = mte_pkg::STS_BUSY;
          end else begin
            out_nxt.status = mte_pkg::STS_RETRY;
          end
          out_nxt.count_after = 16'(ent_wdata.count);
        end
        mte_pkg::REQ_UNLOCK: begin
          if (!mine) begin
            out_nxt.status = mte_pkg::STS_NOTOWNER;
          end else if (ent_r.count == '0) begin
            out_nxt.status = mte_pkg::STS_INVALID;
          end else begin
            ent_we          = 1'b1;
            ent_wdata.count = cnt_dec;
            if (cnt_dec == '0) ent_wdata.ov = 1'b0;
            out_nxt.status  = mte_pkg::STS_OK;
          end
          out_nxt.count_after = 16'(ent_wdata.count);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && use_we) use_mem[row_r] <= use_wdata;
    if (cmd.load) word_r <= use_mem[rd_row];
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && ent_we) ent_mem[ent_waddr] <= ent_wdata;
    if (cmd.load) ent_r <= ent_mem[rd_slot];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
      row_full_r  <= '0;
    end else if (cmd.exec && use_we) begin
      row_valid_r[row_r] <= 1'b1;
      row_full_r[row_r]  <= row_full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_req;
      rv_r  <= row_valid_r[rd_row];
      row_r <= rd_row;
      any_r <= row_any;
    end
    if (cmd.exec) out_r <= out_nxt;
  end

  assign out_res = out_r;

  // a row not marked full must really hold a free slot
  a_free_exists: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && is_alloc && any_r |-> bit_any)
    else $error("allocate found no free bit in a row not marked full");

  a_lock_owner: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && valid_req && out_nxt.status == mte_pkg::STS_OK &&
    (req_r.req_type == mte_pkg::REQ_LOCK || req_r.req_type == mte_pkg::REQ_TRYLOCK)
    |-> ent_we && ent_wdata.ov && ent_wdata.owner == self && ent_wdata.count != '0)
    else $error("granted lock not recorded for requester");

  a_grant_only_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> out_r.granted_slot == '0 || $past(is_alloc))
    else $error("nonzero granted slot on a request other than allocate");

endmodule

FILE: hw/rtl/mutex_table_engine_unit.sv
// the start transfer loads the request with a registered read of the slot table and
//   the in-use bitmap; the execute state then writes back and registers the result
// busy is high in the execute state; a new request is taken only once it is back idle
// reset: synchronous, active low; clears the controller and the per-row valid and
//   full flags at once, so every slot reads free; slot contents are not cleared
// results cannot be stalled: out_valid is high for exactly one cycle with each on out_res
module mutex_table_engine_unit #(
  parameter int NUM_SLOTS   = mte_pkg::NUM_SLOTS_DEF,
  parameter int THREAD_BITS = mte_pkg::THREAD_BITS_DEF,
  parameter int COUNT_BITS  = mte_pkg::COUNT_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  mte_pkg::mte_in_t  in_req,
  output logic              out_valid,
  output mte_pkg::mte_out_t out_res
);

  mte_pkg::cmd_t cmd;

  mte_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .out_valid (out_valid)
  );

  mte_dp #(
    .NUM_SLOTS   (NUM_SLOTS),
    .THREAD_BITS (THREAD_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .in_req  (in_req),
    .out_res (out_res)
  );

endmodule

FILE: dv/testbench.sv
module testbench;
  import mte_pkg::*;

  localparam int SLOTS = NUM_SLOTS_DEF;
  localparam logic [15:0] COUNT_LIMIT = 16'hffff;

  class lock_table_tracker;
    logic        in_use [SLOTS];
    logic [1:0]  kind   [SLOTS];
    logic        owned  [SLOTS];
    logic [15:0] owner  [SLOTS];
    logic [15:0] count  [SLOTS];
    mte_out_t    pending_results[$];
    int          mismatches;
    int          checked;
    int          status_seen[8];

    function new();
      foreach (in_use[i]) in_use[i] = 1'b0;
      mismatches = 0;
      checked = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function logic [2:0] bump_count(int s);
      if (count[s] >= COUNT_LIMIT) return STS_OVERFLOW;
      count[s] = count[s] + 16'd1;
      return STS_OK;
    endfunction

    function logic [2:0] take_slot(int s, logic [15:0] tid);
      owned[s] = 1'b1;
      owner[s] = tid;
      return bump_count(s);
    endfunction

    function void note_request(mte_in_t rq);
      logic [2:0]  sts;
      logic [9:0]  granted;
      logic [15:0] cnt;
      logic        mine;
      int          s;
      sts = STS_INVALID;
      granted = '0;
      cnt = '0;
      s = rq.slot;
      if (rq.req_type == REQ_ALLOC) begin
        sts = STS_NOFREE;
        for (int i = 0; i < SLOTS && i < SLOT_FIELD_LIMIT; i++) begin
          if (!in_use[i]) begin
            in_use[i] = 1'b1;
            if (rq.mutex_kind == {2'b00, KIND_RECURSIVE}) kind[i] = KIND_RECURSIVE;
            else if (rq.mutex_kind == {2'b00, KIND_ERRORCHECK}) kind[i] = KIND_ERRORCHECK;
            else kind[i] = KIND_NORMAL;
            owned[i] = 1'b0;
            owner[i] = '0;
            count[i] = '0;
            sts = STS_OK;
            granted = i[9:0];
            break;
          end
        end
      end else if (rq.req_type <= REQ_UNLOCK && s < SLOTS && in_use[s]) begin
        mine = owned[s] && owner[s] == rq.thread_id;
        if (rq.req_type == REQ_FREE) begin
          in_use[s] = 1'b0;
          owned[s] = 1'b0;
          count[s] = '0;
          sts = STS_OK;
        end else if (rq.req_type == REQ_LOCK || rq.req_type == REQ_TRYLOCK) begin
          if (!owned[s]) begin
            sts = take_slot(s, rq.thread_id);
          end else if (mine) begin
            if (kind[s] == KIND_RECURSIVE) sts = bump_count(s);
            else sts = (rq.req_type == REQ_LOCK) ? STS_DEADLOCK : STS_BUSY;
          end else if (rq.req_type == REQ_TRYLOCK) begin
            sts = STS_BUSY;
          end else if (count[s] != 0) begin
            sts = STS_RETRY;
          end else begin
            sts = take_slot(s, rq.thread_id);
          end
        end else begin
          if (!mine) begin
            sts = STS_NOTOWNER;
          end else if (count[s] == 0) begin
            sts = STS_INVALID;
          end else begin
            count[s] = count[s] - 16'd1;
            if (count[s] == 0) owned[s] = 1'b0;
            sts = STS_OK;
          end
        end
        cnt = in_use[s] ? count[s] : 16'd0;
      end
      pending_results.push_back('{status: sts, granted_slot: granted, count_after: cnt});
    endfunction

    function void check_response(mte_out_t got);
      mte_out_t want;
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: status %0d slot %0d count %0d",
               got.status, got.granted_slot, got.count_after);
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      checked++;
      status_seen[want.status]++;
      if (got.status !== want.status) begin
        $error("status expected %0d actual %0d", want.status, got.status);
        mismatches++;
      end
      if (got.granted_slot !== want.granted_slot) begin
        $error("granted_slot expected %0d actual %0d", want.granted_slot, got.granted_slot);
        mismatches++;
      end
      if (got.count_after !== want.count_after) begin
        $error("count_after expected %0d actual %0d", want.count_after, got.count_after);
        mismatches++;
      end
    endfunction
  endclass

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  mte_in_t  in_req;
  logic     out_valid;
  mte_out_t out_res;

  lock_table_tracker tracker = new();
  int          idle_pct;
  int          sent;
  logic [15:0] thread_pool[4];

  mutex_table_engine_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) tracker.check_response(out_res);
  end

  function automatic mte_in_t make_req(logic [2:0] req, logic [9:0] slot,
                                       logic [15:0] tid, logic [3:0] knd);
    mte_in_t r;
    r.req_type = req;
    r.slot = slot;
    r.thread_id = tid;
    r.mutex_kind = knd;
    return r;
  endfunction

  function automatic mte_in_t random_request();
    logic [2:0]  req;
    logic [9:0]  slot;
    logic [15:0] tid;
    int          pick;
    pick = $urandom_range(99);
    if (pick < 12) req = REQ_ALLOC;
    else if (pick < 22) req = REQ_FREE;
    else if (pick < 50) req = REQ_LOCK;
    else if (pick < 72) req = REQ_TRYLOCK;
    else if (pick < 96) req = REQ_UNLOCK;
    else req = 3'($urandom_range(5, 7));
    slot = ($urandom_range(99) < 80) ? 10'($urandom_range(0, 15)) :
                                       10'($urandom_range(0, 1023));
    tid = ($urandom_range(99) < 85) ? thread_pool[$urandom_range(0, 3)] : 16'($urandom);
    return make_req(req, slot, tid, 4'($urandom_range(0, 15)));
  endfunction

  // one transfer; called and returns at a falling edge
  task automatic send(input mte_in_t rq);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      in_req <= random_request();
      @(negedge clk);
    end
    start <= 1'b1;
    in_req <= rq;
    do @(posedge clk); while (busy);
    tracker.note_request(rq);
    sent++;
    @(negedge clk);
  endtask

  task automatic random_phase(input int pct, input int items);
    idle_pct = pct;
    thread_pool[0] = 16'h0000;
    thread_pool[1] = 16'hffff;
    thread_pool[2] = 16'($urandom);
    thread_pool[3] = 16'($urandom);
    repeat (items) send(random_request());
  endtask

  initial begin
    #1_000_000;
    $display("testbench: FAIL");
    $finish;
  end

  initial begin
    mte_in_t directed[$];
    int      waited;
    rst_n = 1'b0;
    start = 1'b0;
    in_req = '0;
    sent = 0;
    idle_pct = 23;
    foreach (thread_pool[i]) thread_pool[i] = '0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    directed.push_back(make_req(REQ_UNLOCK, 10'd0, 16'h0000, 4'd0));
    directed.push_back(make_req(REQ_LOCK, 10'd1023, 16'h0000, 4'd0));
    directed.push_back(make_req(REQ_ALLOC, 10'd0, 16'h0000, 4'd0));
    directed.push_back(make_req(REQ_ALLOC, 10'd0, 16'h0000, 4'd1));
    directed.push_back(make_req(REQ_ALLOC, 10'd0, 16'h0000, 4'd2));
    directed.push_back(make_req(REQ_ALLOC, 10'd1023, 16'hffff, 4'd15));
    directed.push_back(make_req(REQ_LOCK, 10'd0, 16'h0000, 4'd0));
    directed.push_back(make_req(REQ_LOCK, 10'd0, 16'h0000, 4'd0));
    directed.push_back(make_req(REQ_TRYLOCK, 10'd0, 16'h0000, 4'd0));
    directed.push_back(make_req(REQ_LOCK, 10'd0, 16'hffff, 4'd0));
    directed.push_back(make_req(REQ_TRYLOCK, 10'd0, 16'hffff, 4'd0));
    directed.push_back(make_req(REQ_UNLOCK, 10'd0, 16'hffff, 4'd0));
    directed.push_back(make_req(REQ_UNLOCK, 10'd0, 16'h0000, 4'd0));
    directed.push_back(make_req(REQ_UNLOCK, 10'd0, 16'h0000, 4'd0));
    directed.push_back(make_req(REQ_LOCK, 10'd1, 16'hffff, 4'd0));
    directed.push_back(make_req(REQ_TRYLOCK, 10'd1, 16'hffff, 4'd0));
    directed.push_back(make_req(REQ_LOCK, 10'd1, 16'hffff, 4'd0));
    directed.push_back(make_req(REQ_UNLOCK, 10'd1, 16'hffff, 4'd0));
    directed.push_back(make_req(REQ_TRYLOCK, 10'd2, 16'h1234, 4'd0));
    directed.push_back(make_req(REQ_TRYLOCK, 10'd2, 16'h1234, 4'd0));
    directed.push_back(make_req(REQ_FREE, 10'd1, 16'h0000, 4'd0));
    directed.push_back(make_req(3'd5, 10'd2, 16'h1234, 4'd0));
    directed.push_back(make_req(3'd6, 10'd2, 16'h1234, 4'd0));
    directed.push_back(make_req(3'd7, 10'd2, 16'h1234, 4'd0));
    foreach (directed[i]) send(directed[i]);

    // take eight more slots, then free slots 0 to 11 and free slot 5 a second time
    repeat (8) send(make_req(REQ_ALLOC, 10'd0, 16'h0000, 4'($urandom_range(0, 15))));
    for (int i = 0; i < 12; i++) send(make_req(REQ_FREE, 10'(i), 16'h0000, 4'd0));
    send(make_req(REQ_FREE, 10'd5, 16'h0000, 4'd0));

    // stack five locks on one recursive slot, then probe, unlock and free it
    idle_pct = 0;
    send(make_req(REQ_ALLOC, 10'd0, 16'h0000, 4'd1));
    repeat (5) send(make_req(REQ_LOCK, 10'd0, 16'h5a5a, 4'd0));
    send(make_req(REQ_TRYLOCK, 10'd0, 16'h5a5a, 4'd0));
    send(make_req(REQ_LOCK, 10'd0, 16'ha5a5, 4'd0));
    send(make_req(REQ_UNLOCK, 10'd0, 16'h5a5a, 4'd0));
    send(make_req(REQ_FREE, 10'd0, 16'h0000, 4'd0));

    random_phase(23, 250);
    random_phase(87, 250);
    random_phase(0, 250);
    start <= 1'b0;

    waited = 0;
    while (tracker.pending_results.size() != 0 && waited < 200) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
    if (tracker.pending_results.size() != 0) begin
      $error("%0d expected results never arrived", tracker.pending_results.size());
      tracker.mismatches += tracker.pending_results.size();
    end

    $display("run covered %0d requests with %0d results checked", sent, tracker.checked);
    $display("status mix: ok %0d invalid %0d nofree %0d deadlock %0d",
             tracker.status_seen[STS_OK], tracker.status_seen[STS_INVALID],
             tracker.status_seen[STS_NOFREE], tracker.status_seen[STS_DEADLOCK]);
    $display("  busy %0d notowner %0d retry %0d overflow %0d",
             tracker.status_seen[STS_BUSY], tracker.status_seen[STS_NOTOWNER],
             tracker.status_seen[STS_RETRY], tracker.status_seen[STS_OVERFLOW]);
    if (tracker.mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
